[sv/cmp_pkg.sv]
`default_nettype none
package cmp_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LANE_W = 16;
	localparam int NUM_CH = 4;
	localparam int PIX_W = 8;
	localparam int FRAC_BITS = 12;
	localparam int OFS_W = 16;
	localparam int CH_MAX = 255;
	localparam int COEF_WIDTH_DEF = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_word_t;
	typedef logic [PIX_W-1:0] pix_t;

	localparam cfg_idx_t REG_RED = 3'd0;
	localparam cfg_idx_t REG_GREEN = 3'd1;
	localparam cfg_idx_t REG_BLUE = 3'd2;
	localparam cfg_idx_t REG_ALPHA = 3'd3;
	localparam cfg_idx_t REG_OFFSETS = 3'd4;

	localparam cfg_word_t RED_RST = 64'h0000_1000_0000_0000;
	localparam cfg_word_t GREEN_RST = 64'h0000_0000_1000_0000;
	localparam cfg_word_t BLUE_RST = 64'h0000_0000_0000_1000;
	localparam cfg_word_t ALPHA_RST = 64'h1000_0000_0000_0000;
	localparam cfg_word_t OFFSETS_RST = 64'h0000_0000_0000_0000;

	// offset slot used by each output byte: blue, green, red, alpha
	function automatic logic [1:0] ofs_slot(input logic [1:0] ch);
		logic [1:0] s;
		unique case (ch)
			2'd0: s = 2'd2;
			2'd1: s = 2'd1;
			2'd2: s = 2'd0;
			default: s = 2'd3;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[sv/color_matrix_pixel_unit.sv]
// throughput: one pixel per cycle while the output is not stalled; multiply, two adder stages, clamp stage
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: asynchronous active low, clears valid bits and loads identity matrix
// with zero offsets
`default_nettype none
module color_matrix_pixel_unit
	import cmp_pkg::*;
#(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire cfg_idx_t   cfg_index,
	input  wire cfg_word_t  cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire pix_t       in_byte0,
	input  wire pix_t       in_byte1,
	input  wire pix_t       in_byte2,
	input  wire pix_t       in_byte3,
	output logic            out_valid,
	input  wire logic       out_ready,
	output pix_t            out_byte0,
	output pix_t            out_byte1,
	output pix_t            out_byte2,
	output pix_t            out_byte3
);

	localparam int PROD_W = COEF_WIDTH + PIX_W;
	localparam int SUM4_W = PROD_W + 2;
	localparam int OSH_W = OFS_W + FRAC_BITS;
	localparam int ACC_W = ((SUM4_W > OSH_W) ? SUM4_W : OSH_W) + 1;
	localparam int INT_W = ACC_W - FRAC_BITS;

	cfg_word_t red_q, green_q, blue_q, alpha_q, offsets_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= RED_RST;
			green_q <= GREEN_RST;
			blue_q <= BLUE_RST;
			alpha_q <= ALPHA_RST;
			offsets_q <= OFFSETS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RED: red_q <= cfg_data;
				REG_GREEN: green_q <= cfg_data;
				REG_BLUE: blue_q <= cfg_data;
				REG_ALPHA: alpha_q <= cfg_data;
				REG_OFFSETS: offsets_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cfg_word_t rows [NUM_CH];
	assign rows[0] = blue_q;
	assign rows[1] = green_q;
	assign rows[2] = red_q;
	assign rows[3] = alpha_q;

	pix_t px [NUM_CH];
	assign px[0] = in_byte0;
	assign px[1] = in_byte1;
	assign px[2] = in_byte2;
	assign px[3] = in_byte3;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0] prod_s1 [NUM_CH][NUM_CH];
	logic signed [ACC_W-1:0] suma_s2 [NUM_CH];
	logic signed [ACC_W-1:0] sumb_s2 [NUM_CH];
	logic signed [ACC_W-1:0] acc_s3 [NUM_CH];
	pix_t res_s4 [NUM_CH];

	assign en = !v_s4 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		logic signed [COEF_WIDTH+PIX_W:0] full_prod [NUM_CH];
		logic signed [OFS_W-1:0] ofs;
		logic signed [ACC_W-1:0] ofs_sh;
		logic [INT_W-1:0] int_part;

		for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
			assign full_prod[i] = $signed(rows[c][LANE_W*i +: COEF_WIDTH])
				* $signed({1'b0, px[i]});
		end

		assign ofs = $signed(offsets_q[OFS_W*ofs_slot(2'(c)) +: OFS_W]);
		assign ofs_sh = ACC_W'(ofs) <<< FRAC_BITS;
		assign int_part = acc_s3[c][ACC_W-1:FRAC_BITS];

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < NUM_CH; i++) begin
					prod_s1[c][i] <= PROD_W'(full_prod[i]);
				end
				suma_s2[c] <= ACC_W'(prod_s1[c][0]) + ACC_W'(prod_s1[c][1]);
				sumb_s2[c] <= ACC_W'(prod_s1[c][2]) + ACC_W'(prod_s1[c][3]) + ofs_sh;
				acc_s3[c] <= suma_s2[c] + sumb_s2[c];
				priority if (acc_s3[c][ACC_W-1]) begin
					res_s4[c] <= '0;
				end else if (int_part > INT_W'(CH_MAX)) begin
					res_s4[c] <= PIX_W'(CH_MAX);
				end else begin
					res_s4[c] <= int_part[PIX_W-1:0];
				end
			end
		end
	end

	assign out_valid = v_s4;
	assign out_byte0 = res_s4[0];
	assign out_byte1 = res_s4[1];
	assign out_byte2 = res_s4[2];
	assign out_byte3 = res_s4[3];

`ifndef SYNTHESIS
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline refuses input while output is empty");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted word missing from first stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !in_ready) |=> (v_s3 && $stable(acc_s3[0]) && $stable(acc_s3[3])))
		else $error("stalled stage lost its word");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !v_s4) |=> v_s4)
		else $error("word did not reach the output stage");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
	import cmp_pkg::*;

	typedef logic [NUM_CH-1:0][PIX_W-1:0] quad_t;

	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTINGS_PER_REGIME = 4;
	localparam int PIXELS_PER_SETTING = 92;

	class pixel_scoreboard;
		cfg_word_t red_w;
		cfg_word_t green_w;
		cfg_word_t blue_w;
		cfg_word_t alpha_w;
		cfg_word_t offset_w;
		quad_t due_pixels[$];
		int fail_count;
		int matched;

		function new();
			red_w = RED_RST;
			green_w = GREEN_RST;
			blue_w = BLUE_RST;
			alpha_w = ALPHA_RST;
			offset_w = OFFSETS_RST;
			fail_count = 0;
			matched = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_word_t data);
			case (idx)
				REG_RED: red_w = data;
				REG_GREEN: green_w = data;
				REG_BLUE: blue_w = data;
				REG_ALPHA: alpha_w = data;
				REG_OFFSETS: offset_w = data;
				default: ;
			endcase
		endfunction

		// exact sum in units of 2^-12, then clamp and drop the fraction
		function pix_t grade_channel(cfg_word_t row, logic [OFS_W-1:0] ofs, quad_t px);
			logic signed [63:0] acc;
			logic signed [63:0] term;
			logic signed [LANE_W-1:0] w;
			logic [LANE_W-1:0] lane;
			int i;
			acc = $signed({{(64-OFS_W){ofs[OFS_W-1]}}, ofs}) <<< FRAC_BITS;
			for (i = 0; i < NUM_CH; i++) begin
				lane = row[i*LANE_W +: LANE_W] << (LANE_W - COEF_WIDTH_DEF);
				w = $signed(lane) >>> (LANE_W - COEF_WIDTH_DEF);
				term = w;
				acc = acc + term * $signed({{(64-PIX_W){1'b0}}, px[i]});
			end
			if (acc < 0)
				return '0;
			if ((acc >>> FRAC_BITS) > CH_MAX)
				return pix_t'(CH_MAX);
			return pix_t'(acc >>> FRAC_BITS);
		endfunction

		function quad_t transform_pixel(quad_t px);
			quad_t r;
			r[0] = grade_channel(blue_w, offset_w[47:32], px);
			r[1] = grade_channel(green_w, offset_w[31:16], px);
			r[2] = grade_channel(red_w, offset_w[15:0], px);
			r[3] = grade_channel(alpha_w, offset_w[63:48], px);
			return r;
		endfunction

		function void note_pixel(quad_t px);
			due_pixels.insert(due_pixels.size(), transform_pixel(px));
		endfunction

		function int pending();
			return due_pixels.size();
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			fail_count++;
		endtask

		task check_pixel(quad_t got);
			quad_t want;
			int ch;
			if (due_pixels.size() == 0) begin
				report($sformatf("output word %h with nothing expected", got));
				return;
			end
			want = due_pixels.pop_front();
			for (ch = 0; ch < NUM_CH; ch++) begin
				if (got[ch] !== want[ch])
					report($sformatf("word %0d out_byte%0d: got %0d, expected %0d",
						matched, ch, got[ch], want[ch]));
			end
			matched++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	cfg_word_t cfg_data;
	logic in_valid;
	logic in_ready;
	pix_t in_byte0;
	pix_t in_byte1;
	pix_t in_byte2;
	pix_t in_byte3;
	logic out_valid;
	logic out_ready;
	pix_t out_byte0;
	pix_t out_byte1;
	pix_t out_byte2;
	pix_t out_byte3;

	pixel_scoreboard sb;
	int send_idle;
	int recv_idle;
	int cycle_count;
	int sent;
	int settings_loaded;
	int reg_writes;

	color_matrix_pixel_unit #(
		.COEF_WIDTH(COEF_WIDTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte0(in_byte0),
		.in_byte1(in_byte1),
		.in_byte2(in_byte2),
		.in_byte3(in_byte3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte0(out_byte0),
		.out_byte1(out_byte1),
		.out_byte2(out_byte2),
		.out_byte3(out_byte3)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				sb.pending());
			$display("color_matrix_pixel_unit: mismatch");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && out_ready)
			sb.check_pixel({out_byte3, out_byte2, out_byte1, out_byte0});
	end

	function automatic cfg_word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// weights within about +-1.5, so sums often land inside 0..255
	function automatic cfg_word_t mild_row();
		cfg_word_t r;
		int v;
		int i;
		for (i = 0; i < NUM_CH; i++) begin
			v = $urandom_range(12288);
			v = v - 6144;
			r[i*LANE_W +: LANE_W] = v[LANE_W-1:0];
		end
		return r;
	endfunction

	function automatic cfg_word_t mild_offsets();
		cfg_word_t r;
		int v;
		int i;
		for (i = 0; i < NUM_CH; i++) begin
			v = $urandom_range(600);
			v = v - 300;
			r[i*OFS_W +: OFS_W] = v[OFS_W-1:0];
		end
		return r;
	endfunction

	function automatic pix_t rand_byte();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return pix_t'($urandom);
		endcase
	endfunction

	function automatic quad_t rand_pixel();
		return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input cfg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic load_setting(input cfg_word_t red, input cfg_word_t green,
		input cfg_word_t blue, input cfg_word_t alpha, input cfg_word_t offs);
		write_reg(REG_RED, red);
		write_reg(REG_GREEN, green);
		write_reg(REG_BLUE, blue);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_OFFSETS, offs);
		if ($urandom_range(1) == 1)
			write_reg(cfg_idx_t'(REG_OFFSETS + 1 + $urandom_range(2)), rand_word());
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic load_random_setting();
		int kind;
		kind = $urandom_range(3);
		if (kind == 0)
			load_setting(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
		else
			load_setting(mild_row(), mild_row(), mild_row(), mild_row(), mild_offsets());
	endtask

	task automatic send_pixel(input quad_t px);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte0 <= px[0];
		in_byte1 <= px[1];
		in_byte2 <= px[2];
		in_byte3 <= px[3];
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(px);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int regime;
		int s;
		int n;
		sb = new();
		cycle_count = 0;
		sent = 0;
		settings_loaded = 0;
		reg_writes = 0;
		send_idle = 14;
		recv_idle = 51;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_RED;
		cfg_data = '0;
		in_valid = 1'b0;
		in_byte0 = '0;
		in_byte1 = '0;
		in_byte2 = '0;
		in_byte3 = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// identity matrix out of reset
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h8001_7FFE);

		// distinct offsets expose the slot of each channel
		drain_pipe();
		load_setting(RED_RST, GREEN_RST, BLUE_RST, ALPHA_RST,
			{16'd40, 16'd30, 16'd20, 16'd10});
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);

		// largest positive weights
		drain_pipe();
		load_setting({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, '0);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0001);

		// most negative weights against extreme offsets
		drain_pipe();
		load_setting({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
			{16'h0001, 16'h8000, 16'h0000, 16'h7FFF});
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);

		// tiny negative weights pull 255 just under, fraction dropped
		drain_pipe();
		load_setting({4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}},
			{4{16'h00FF}});
		send_pixel(32'h0000_0000);
		send_pixel(32'h0101_0101);
		send_pixel(32'hFFFF_FFFF);

		// pure fractions, a negative offset and an offset above range
		drain_pipe();
		load_setting({4{16'h0001}}, {4{16'h0001}}, {4{16'h0001}}, {4{16'h0001}},
			{16'hFFFF, 16'h0000, 16'h0100, 16'h0000});
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);

		// permuted half weights
		drain_pipe();
		load_setting(64'h0000_0000_0000_0800, 64'h0800_0000_0000_0000,
			64'h0000_0800_0000_0000, 64'h0000_0000_0800_0000, '0);
		send_pixel(32'h4080_C0FF);
		send_pixel(32'hA55A_3CC3);

		for (regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					send_idle = 14;
					recv_idle = 51;
				end
				1: begin
					send_idle = 51;
					recv_idle = 14;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (s = 0; s < SETTINGS_PER_REGIME; s++) begin
				drain_pipe();
				load_random_setting();
				for (n = 0; n < PIXELS_PER_SETTING; n++) begin
					if (s == 1 && n == PIXELS_PER_SETTING / 2)
						drain_pipe();
					send_pixel(rand_pixel());
				end
			end
		end

		drain_pipe();
		$display("run covered %0d pixels under %0d matrix settings (%0d register writes),",
			sent, settings_loaded, reg_writes);
		$display("with sender and receiver stalls swapped and then removed");
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("color_matrix_pixel_unit: match");
		else
			$display("color_matrix_pixel_unit: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
sv/cmp_pkg.sv
sv/color_matrix_pixel_unit.sv
tb/testbench.sv
